FILE: rtl/polar_stereo_xy_to_latlon_unit_defines.svh
// Assertion macros for the polar stereographic inverse projection unit
`ifndef POLAR_STEREO_XY_TO_LATLON_UNIT_DEFINES_SVH
`define POLAR_STEREO_XY_TO_LATLON_UNIT_DEFINES_SVH

// same-cycle implication
`define PSXY_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psxy assertion failed");

// next-cycle implication
`define PSXY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psxy assertion failed");

`endif

FILE: rtl/psxy_pkg.sv
// Shared constants, tables and types of the polar stereographic inverse unit
`default_nettype none
package psxy_pkg;

    localparam int CORDIC_STEPS_DEF = 32;
    localparam int ATAN_LEN = 48;
    localparam int SQRT_STEPS = 32;
    localparam int ANG_W = 34;

    localparam logic signed [ANG_W-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0] SIN_GAIN = 34'sd652032874;

    localparam logic signed [57:0] SER_C1 = 58'sd2294251;
    localparam logic signed [57:0] SER_C2 = 58'sd4492;
    localparam logic signed [57:0] SER_C3 = 58'sd12;
    localparam logic signed [29:0] POLE_DEG = 30'sd377487360;
    localparam logic [63:0] POLE_SUM = 64'd655;

    // atan(2^-i), 2^32 units per turn
    localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
        30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162,
        30'd81, 30'd40, 30'd20, 30'd10, 30'd5, 30'd2, 30'd1,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
    };

    typedef enum logic [1:0] {
        REG_HEMISPHERE       = 2'd0,
        REG_CENTRAL_MERIDIAN = 2'd1,
        REG_SCALE_FACTOR     = 2'd2
    } cfg_reg_t;

endpackage
`default_nettype wire

FILE: rtl/psxy_delay.sv
// Enabled shift line that keeps side data aligned with the pipeline
`default_nettype none
module psxy_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/psxy_isqrt.sv
// Pipelined integer square root, one result bit per stage
`default_nettype none
module psxy_isqrt import psxy_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] sum,
    output logic [31:0] rho
);

    logic [63:0] n_reg [SQRT_STEPS-1];
    logic [63:0] r_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [63:0] ni;
        logic [63:0] ri;
        logic [63:0] trial;
        logic        fits;

        if (k == 0)
        begin : g_first
            assign ni = sum;
            assign ri = '0;
        end
        else
        begin : g_rest
            assign ni = n_reg[k-1];
            assign ri = r_reg[k-1];
        end

        assign trial = ri + BITV;
        assign fits = (ni >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= fits ? ((ri >> 1) + BITV) : (ri >> 1);
            end
        end

        if (k < SQRT_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k] <= fits ? (ni - trial) : ni;
                end
            end
        end
    end

    assign rho = r_reg[SQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

FILE: rtl/psxy_vec_cordic.sv
// Pipelined vectoring CORDIC, first-quadrant arctangent with clamp
`default_nettype none
module psxy_vec_cordic import psxy_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        en,
    input  logic [39:0] xin,
    input  logic [39:0] yin,
    output logic [30:0] ang
);

    localparam int XW = 44;

    logic signed [XW-1:0]    x_reg [STEPS-1];
    logic signed [XW-1:0]    y_reg [STEPS-1];
    logic signed [ANG_W-1:0] z_reg [STEPS];
    logic [30:0]             ang_reg;
    logic signed [ANG_W-1:0] zf;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [XW-1:0]    xi;
        logic signed [XW-1:0]    yi;
        logic signed [ANG_W-1:0] zi;
        logic signed [ANG_W-1:0] tab;

        if (i == 0)
        begin : g_first
            assign xi = $signed({{(XW-40){1'b0}}, xin});
            assign yi = $signed({{(XW-40){1'b0}}, yin});
            assign zi = '0;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        assign tab = $signed(ANG_W'(ATAN_TAB[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[i] <= yi[XW-1] ? (zi - tab) : (zi + tab);
            end
        end

        if (i < STEPS - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!yi[XW-1])
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                    end
                    else
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                    end
                end
            end
        end
    end

    assign zf = z_reg[STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zf[ANG_W-1])
            begin
                ang_reg <= '0;
            end
            else if (zf > QUARTER)
            begin
                ang_reg <= QUARTER[30:0];
            end
            else
            begin
                ang_reg <= zf[30:0];
            end
        end
    end

    assign ang = ang_reg;

endmodule
`default_nettype wire

FILE: rtl/psxy_sin_cordic.sv
// Pipelined rotation CORDIC sine of a binary angle, Q30 result
`default_nettype none
module psxy_sin_cordic import psxy_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [31:0]             angle,
    output logic signed [ANG_W-1:0] sine
);

    logic signed [ANG_W-1:0] v0_reg;
    logic signed [ANG_W-1:0] x_reg [STEPS-1];
    logic signed [ANG_W-1:0] v_reg [STEPS-1];
    logic signed [ANG_W-1:0] y_reg [STEPS];
    logic signed [ANG_W-1:0] v0_next;

    // fold into [-quarter, quarter]
    always_comb
    begin
        v0_next = ANG_W'($signed(angle));
        if (v0_next > QUARTER)
        begin
            v0_next = HALF - v0_next;
        end
        else if (v0_next < -QUARTER)
        begin
            v0_next = -HALF - v0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg <= v0_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [ANG_W-1:0] xi;
        logic signed [ANG_W-1:0] yi;
        logic signed [ANG_W-1:0] vi;
        logic signed [ANG_W-1:0] tab;

        if (i == 0)
        begin : g_first
            assign xi = SIN_GAIN;
            assign yi = '0;
            assign vi = v0_reg;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign vi = v_reg[i-1];
        end

        assign tab = $signed(ANG_W'(ATAN_TAB[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg[i] <= vi[ANG_W-1] ? (yi - (xi >>> i)) : (yi + (xi >>> i));
            end
        end

        if (i < STEPS - 1)
        begin : g_xv
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!vi[ANG_W-1])
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        v_reg[i] <= vi - tab;
                    end
                    else
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        v_reg[i] <= vi + tab;
                    end
                end
            end
        end
    end

    assign sine = y_reg[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/polar_stereo_xy_to_latlon_unit.sv
// Polar stereographic inverse projection unit, top level.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// The depth comes from the 32-stage square root and the two chained CORDIC pipelines.
// Reset: registers return to hemisphere north, meridian 45 deg, scale zero; pipeline empty.
`default_nettype none
`include "polar_stereo_xy_to_latlon_unit_defines.svh"
module polar_stereo_xy_to_latlon_unit import psxy_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // x_coord[31:0], y_coord[63:32]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // latitude[29:0], longitude[61:30], zero[63:62]
    output logic [0:0]  m_tuser,    // at_pole[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int VLD_DLY  = 2 * CORDIC_STEPS + 45;
    localparam int POLE_DLY = 2 * CORDIC_STEPS + 41;
    localparam int FLG_DLY  = CORDIC_STEPS + 4;
    localparam int LON_DLY  = CORDIC_STEPS + 38;
    localparam int CHI_DLY  = CORDIC_STEPS + 3;

    // configuration
    logic               hemi_reg;
    logic signed [30:0] cm_reg;
    logic [47:0]        scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hemi_reg  <= 1'b0;
            cm_reg    <= 31'sd188743680;
            scale_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HEMISPHERE:       hemi_reg  <= cfg_data[0];
                REG_CENTRAL_MERIDIAN: cm_reg    <= $signed(cfg_data[30:0]);
                REG_SCALE_FACTOR:     scale_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic en;
    logic m_tvalid_reg;
    assign en = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // input capture and magnitudes
    logic signed [31:0] x1_reg;
    logic signed [31:0] y1_reg;
    logic [31:0]        ax2_reg;
    logic [31:0]        ay2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= $signed(s_tdata[31:0]);
            y1_reg  <= $signed(s_tdata[63:32]);
            ax2_reg <= x1_reg[31] ? 32'(-x1_reg) : 32'(x1_reg);
            ay2_reg <= y1_reg[31] ? 32'(-y1_reg) : 32'(y1_reg);
        end
    end

    // radius squared and pole test
    logic [63:0] sqx3_reg;
    logic [63:0] sqy3_reg;
    logic [63:0] sum4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx3_reg <= 64'(ax2_reg) * 64'(ax2_reg);
            sqy3_reg <= 64'(ay2_reg) * 64'(ay2_reg);
            sum4_reg <= sqx3_reg + sqy3_reg;
        end
    end

    logic [31:0] rho;

    psxy_isqrt u_isqrt (
        .clk (clk),
        .en  (en),
        .sum (sum4_reg),
        .rho (rho)
    );

    // T = rho * scale, 80-bit exact
    logic [55:0] pa_reg;
    logic [55:0] pb_reg;
    logic [79:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= 56'(rho) * 56'(scale_reg[23:0]);
            pb_reg   <= 56'(rho) * 56'(scale_reg[47:24]);
            prod_reg <= 80'(pa_reg) + (80'(pb_reg) << 24);
        end
    end

    // scale (1, T) down to 40 bits
    logic [4:0]  hi_len;
    logic [5:0]  t_sh;
    logic [39:0] xv39_reg;
    logic [39:0] yv39_reg;

    always_comb
    begin
        hi_len = 5'd1;
        for (int i = 0; i < 16; i++)
        begin
            if (prod_reg[64 + i])
            begin
                hi_len = 5'(i + 1);
            end
        end
        t_sh = 6'd24 + 6'(hi_len);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xv39_reg <= 40'd1 << (6'd40 - 6'(hi_len));
            yv39_reg <= 40'(prod_reg >> t_sh);
        end
    end

    logic [30:0] t_ang;

    psxy_vec_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_vec_lat (
        .clk  (clk),
        .en   (en),
        .xin  (xv39_reg),
        .yin  (yv39_reg),
        .ang  (t_ang)
    );

    // chi and sine arguments
    logic signed [ANG_W-1:0] chi_next;
    logic signed [ANG_W-1:0] chi_reg;
    logic [31:0]             a2_reg;
    logic [31:0]             a4_reg;
    logic [31:0]             a6_reg;

    assign chi_next = QUARTER - $signed({2'b00, t_ang, 1'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chi_reg <= chi_next;
            a2_reg  <= {chi_next[30:0], 1'b0};
            a4_reg  <= {chi_next[29:0], 2'b00};
            a6_reg  <= {chi_next[30:0], 1'b0} + {chi_next[29:0], 2'b00};
        end
    end

    logic signed [ANG_W-1:0] s2;
    logic signed [ANG_W-1:0] s4;
    logic signed [ANG_W-1:0] s6;

    psxy_sin_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_sin2 (
        .clk   (clk),
        .en    (en),
        .angle (a2_reg),
        .sine  (s2)
    );

    psxy_sin_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_sin4 (
        .clk   (clk),
        .en    (en),
        .angle (a4_reg),
        .sine  (s4)
    );

    psxy_sin_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_sin6 (
        .clk   (clk),
        .en    (en),
        .angle (a6_reg),
        .sine  (s6)
    );

    logic signed [ANG_W-1:0] chi_d;

    psxy_delay #(
        .WIDTH (ANG_W),
        .DEPTH (CHI_DLY)
    ) u_chi_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (chi_reg),
        .dout  (chi_d)
    );

    // ellipsoid series
    logic signed [57:0]      m1_reg;
    logic signed [57:0]      m2_reg;
    logic signed [57:0]      m3_reg;
    logic signed [57:0]      ser_sum;
    logic signed [27:0]      ser_reg;
    logic signed [ANG_W-1:0] latt_next;
    logic signed [ANG_W-1:0] latt_reg;

    assign ser_sum = m1_reg + m2_reg + m3_reg + 58'sd536870912;

    always_comb
    begin
        latt_next = chi_d + ANG_W'(ser_reg);
        if (latt_next > QUARTER)
        begin
            latt_next = QUARTER;
        end
        else if (latt_next < -QUARTER)
        begin
            latt_next = -QUARTER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= 58'(s2) * SER_C1;
            m2_reg   <= 58'(s4) * SER_C2;
            m3_reg   <= 58'(s6) * SER_C3;
            ser_reg  <= 28'(ser_sum >>> 30);
            latt_reg <= latt_next;
        end
    end

    // longitude path
    logic [2:0]  flg_next;
    logic [2:0]  flg_d;
    logic [31:0] mx;
    logic [4:0]  mx_msb;
    logic [5:0]  s3_reg;
    logic [31:0] aa3_reg;
    logic [31:0] ab3_reg;
    logic [39:0] vx4_reg;
    logic [39:0] vy4_reg;

    // {x zero, b negative, a negative}
    assign flg_next[0] = hemi_reg ? (!x1_reg[31] && (x1_reg != 32'sd0)) : x1_reg[31];
    assign flg_next[1] = hemi_reg ? y1_reg[31] : (!y1_reg[31] && (y1_reg != 32'sd0));
    assign flg_next[2] = (x1_reg == 32'sd0);

    psxy_delay #(
        .WIDTH (3),
        .DEPTH (FLG_DLY)
    ) u_flg_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (flg_next),
        .dout  (flg_d)
    );

    always_comb
    begin
        mx = (ax2_reg >= ay2_reg) ? ax2_reg : ay2_reg;
        mx_msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mx[i])
            begin
                mx_msb = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg  <= 6'd39 - 6'(mx_msb);
            aa3_reg <= ax2_reg;
            ab3_reg <= ay2_reg;
            vx4_reg <= 40'(ab3_reg) << s3_reg;
            vy4_reg <= 40'(aa3_reg) << s3_reg;
        end
    end

    logic [30:0] lon_ang;

    psxy_vec_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_vec_lon (
        .clk  (clk),
        .en   (en),
        .xin  (vx4_reg),
        .yin  (vy4_reg),
        .ang  (lon_ang)
    );

    logic signed [ANG_W-1:0] lont_next;
    logic signed [ANG_W-1:0] lont_reg;
    logic signed [40:0]      lon_p45;
    logic signed [40:0]      lon_q;
    logic signed [40:0]      lon_r;
    logic [31:0]             lon7_reg;
    logic [31:0]             lon_d;

    always_comb
    begin
        lont_next = $signed({3'b000, lon_ang});
        if (flg_d[1])
        begin
            lont_next = HALF - lont_next;
        end
        if (flg_d[0])
        begin
            lont_next = -lont_next;
        end
        if (hemi_reg)
        begin
            lont_next = -lont_next;
        end
        if (flg_d[2])
        begin
            lont_next = flg_d[1] ? HALF : '0;
        end
    end

    assign lon_p45 = 41'(lont_reg) * 41'sd45;
    assign lon_q = (lon_p45 + 41'sd64) >>> 7;
    assign lon_r = lon_q - 41'(cm_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lont_reg <= lont_next;
            lon7_reg <= lon_r[31:0];
        end
    end

    psxy_delay #(
        .WIDTH (32),
        .DEPTH (LON_DLY)
    ) u_lon_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (lon7_reg),
        .dout  (lon_d)
    );

    // side data
    logic pole_d;
    logic [1:0] vl_d;

    psxy_delay #(
        .WIDTH (1),
        .DEPTH (POLE_DLY)
    ) u_pole_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (sum4_reg <= POLE_SUM),
        .dout  (pole_d)
    );

    psxy_delay #(
        .WIDTH (2),
        .DEPTH (VLD_DLY)
    ) u_vld_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   ({s_tlast, s_tvalid}),
        .dout  (vl_d)
    );

    // output stage
    logic signed [ANG_W-1:0] slat;
    logic signed [39:0]      lat_p45;
    logic signed [39:0]      lat_q;
    logic signed [29:0]      lat_next;
    logic signed [31:0]      neg_cm;
    logic signed [29:0]      lat_out_reg;
    logic [31:0]             lon_out_reg;
    logic                    pole_out_reg;
    logic                    last_out_reg;

    assign slat = hemi_reg ? -latt_reg : latt_reg;
    assign lat_p45 = 40'(slat) * 40'sd45;
    assign lat_q = (lat_p45 + 40'sd64) >>> 7;
    assign neg_cm = 32'sd0 - 32'(cm_reg);

    always_comb
    begin
        if (pole_d)
        begin
            lat_next = hemi_reg ? -POLE_DEG : POLE_DEG;
        end
        else
        begin
            lat_next = lat_q[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= vl_d[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_out_reg  <= lat_next;
            lon_out_reg  <= pole_d ? 32'(neg_cm) : lon_d;
            pole_out_reg <= pole_d;
            last_out_reg <= vl_d[1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {2'b00, lon_out_reg, lat_out_reg};
    assign m_tuser = pole_out_reg;
    assign m_tlast = last_out_reg;

    `PSXY_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `PSXY_ASSERT_IMP(a_pole_lat, clk, rst_n, m_tvalid && pole_out_reg,
        (lat_out_reg == POLE_DEG) || (lat_out_reg == -POLE_DEG))
    `PSXY_ASSERT_IMP(a_lat_range, clk, rst_n, m_tvalid,
        (lat_out_reg <= POLE_DEG) && (lat_out_reg >= -POLE_DEG))
    `PSXY_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !s_tready,
        $stable(latt_reg) && $stable(lon_d))

endmodule
`default_nettype wire

FILE: test/polar_stereo_xy_to_latlon_unit_tb.sv
// Self-checking testbench for the polar stereographic inverse projection unit
`default_nettype none
module polar_stereo_xy_to_latlon_unit_tb;
    import psxy_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_TURN = 64'sd1073741824;
    localparam longint H_TURN = 64'sd2147483648;
    localparam longint C_SER1 = 64'sd2294251;
    localparam longint C_SER2 = 64'sd4492;
    localparam longint C_SER3 = 64'sd12;
    localparam longint POLE_LAT = 64'sd377487360;
    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int LATENCY = 2 * STEPS + 46;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [29:0] lat;
        logic [31:0] lon;
        logic        pole;
        logic        last;
    } geo_word_t;

    class geo_scoreboard;
        bit          hem;
        longint      meridian;
        bit [47:0]   scale;
        geo_word_t   geo_q[$];
        int          errors;
        int          checked;

        function new();
            hem = 0;
            meridian = 188743680;
            scale = 0;
        endfunction

        function automatic longint vec_angle(longint xv, longint yv);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < STEPS; i++) begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (yv >= 0) begin
                    xv += dx; yv -= dy; z += longint'(ATAN_TAB[i]);
                end else begin
                    xv -= dx; yv += dy; z -= longint'(ATAN_TAB[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > Q_TURN) z = Q_TURN;
            return z;
        endfunction

        function automatic longint sine_q30(bit [31:0] a);
            longint v, xv, yv, dx, dy;
            v = longint'(a);
            xv = 64'sd652032874;
            yv = 0;
            if (v >= H_TURN) v -= 2 * H_TURN;
            if (v > Q_TURN) v = H_TURN - v;
            if (v < -Q_TURN) v = -H_TURN - v;
            for (int i = 0; i < STEPS; i++) begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (v >= 0) begin
                    xv -= dx; yv += dy; v -= longint'(ATAN_TAB[i]);
                end else begin
                    xv += dx; yv -= dy; v += longint'(ATAN_TAB[i]);
                end
            end
            return yv;
        endfunction

        function automatic bit [63:0] int_sqrt(bit [63:0] n);
            bit [63:0] res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > n) bt >>= 2;
            while (bt != 0) begin
                if (n >= res + bt) begin
                    n -= res + bt;
                    res = (res >> 1) + bt;
                end else begin
                    res >>= 1;
                end
                bt >>= 2;
            end
            return res;
        endfunction

        function automatic void note_point(bit [31:0] xi, bit [31:0] yi, bit last);
            longint x, y, sgn, lat, lon, t, chi, latt, lont, a, b, aa, ab, m, ang;
            bit [63:0] ax, ay, sum, rho, hi;
            bit [127:0] full;
            int sh, s;
            geo_word_t w;
            x = longint'($signed(xi));
            y = longint'($signed(yi));
            sgn = hem ? -1 : 1;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            sum = ax * ax + ay * ay;
            w.pole = 0;
            if (sum <= 64'd655) begin
                lat = sgn * POLE_LAT;
                lon = 0;
                w.pole = 1;
            end else begin
                rho = int_sqrt(sum);
                full = {64'd0, rho} * {80'd0, scale};
                hi = full[127:64];
                sh = 25;
                while (hi > 1) begin
                    sh++;
                    hi >>= 1;
                end
                t = vec_angle(longint'(64'd1 << (64 - sh)), longint'(64'(full >> sh)));
                chi = Q_TURN - 2 * t;
                latt = chi + ((C_SER1 * sine_q30(32'(chi * 2)) + C_SER2 * sine_q30(32'(chi * 4))
                               + C_SER3 * sine_q30(32'(chi * 6)) + (Q_TURN >>> 1)) >>> 30);
                if (latt > Q_TURN) latt = Q_TURN;
                if (latt < -Q_TURN) latt = -Q_TURN;
                lat = (sgn * latt * 45 + 64) >>> 7;
                a = sgn * x;
                b = -sgn * y;
                if (x == 0) begin
                    lont = (b < 0) ? H_TURN : 0;
                end else begin
                    aa = a < 0 ? -a : a;
                    ab = b < 0 ? -b : b;
                    m = aa > ab ? aa : ab;
                    s = 0;
                    while ((m << s) < (64'sd1 <<< 39)) s++;
                    ang = vec_angle(ab << s, aa << s);
                    if (b < 0) ang = H_TURN - ang;
                    if (a < 0) ang = -ang;
                    lont = sgn * ang;
                end
                lon = (lont * 45 + 64) >>> 7;
            end
            lon -= meridian;
            w.lat = lat[29:0];
            w.lon = lon[31:0];
            w.last = last;
            geo_q.push_back(w);
        endfunction

        function automatic void check_result(geo_word_t got);
            geo_word_t e;
            if (geo_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            e = geo_q.pop_front();
            checked++;
            if (got.lat !== e.lat) begin
                $display("%0t: latitude exp %h act %h", $time, e.lat, got.lat);
                errors++;
            end
            if (got.lon !== e.lon) begin
                $display("%0t: longitude exp %h act %h", $time, e.lon, got.lon);
                errors++;
            end
            if (got.pole !== e.pole) begin
                $display("%0t: at_pole exp %b act %b", $time, e.pole, got.pole);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: tlast exp %b act %b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_HEMISPHERE;
    logic [47:0] cfg_data = '0;

    polar_stereo_xy_to_latlon_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    geo_scoreboard sb = new();
    int  idle_cycles = 0;
    int  points_sent = 0;
    int  cfg_writes = 0;
    int  burst_left = 0;
    bit  no_gaps = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_cnt = 0;
    int  rx_cyc = 0;

    // handshakes are sampled at the falling edge, before the rising edge that consumes them
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result({m_tdata[29:0], m_tdata[61:30], m_tuser[0], m_tlast});
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("polar_stereo_xy_to_latlon_unit_tb: FAIL");
            $finish;
        end
    end

    // receiver stall pattern plus long hold-off on request
    always @(posedge clk)
    begin
        rx_cyc++;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 0;
        end else begin
            case ((rx_cyc / 256) % 4)
                0: m_tready <= 1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= (rx_cyc % 4) != 0;
                default: m_tready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    task automatic send_point(bit [31:0] x, bit [31:0] y, bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (!no_gaps && gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= {y, x};
        s_tlast <= last;
        forever begin
            @(negedge clk);
            if (s_tready) break;
            @(posedge clk);
        end
        @(posedge clk);
        sb.note_point(x, y, last);
        points_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.geo_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, bit [47:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge clk);
            if (cfg_ready) break;
            @(posedge clk);
        end
        @(posedge clk);
        cfg_writes++;
        case (idx)
            REG_HEMISPHERE:       sb.hem = val[0];
            REG_CENTRAL_MERIDIAN: sb.meridian = longint'($signed(val[30:0]));
            default:              sb.scale = val;
        endcase
    endtask

    task automatic set_config(bit hem, longint mer, bit [47:0] scl);
        write_reg(REG_HEMISPHERE, {47'd0, hem});
        write_reg(REG_CENTRAL_MERIDIAN, {17'd0, mer[30:0]});
        write_reg(REG_SCALE_FACTOR, scl);
        cfg_valid <= 0;
    endtask

    task automatic random_point();
        bit [31:0] x, y;
        case ($urandom_range(0, 9))
            0, 1, 2: begin x = $urandom; y = $urandom; end
            3, 4, 5: begin
                x = $urandom_range(0, 2097152) - 1048576;
                y = $urandom_range(0, 2097152) - 1048576;
            end
            6, 7: begin x = $urandom_range(0, 60) - 30; y = $urandom_range(0, 60) - 30; end
            8: begin x = 0; y = $urandom; end
            default: begin x = $urandom; y = $urandom_range(0, 4) - 2; end
        endcase
        send_point(x, y, $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        bit [63:0] r;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset settings: scale zero, so everything lands at the pole latitude
        send_point(32'd1000, 32'd0, 0);
        send_point(32'h7fffffff, 32'h7fffffff, 1);
        drain();

        set_config(0, 64'sd754974720, 48'd1 << 34);
        send_point(32'd0, 32'd0, 0);
        send_point(32'd25, 32'd5, 0);        // sum 650, pole
        send_point(32'd25, 32'd6, 1);        // sum 661, just off the pole
        send_point(-32'sd18, -32'sd18, 0);
        send_point(32'd0, 32'd1000, 0);
        send_point(32'd0, -32'sd1000, 0);
        send_point(32'd1000, 32'd0, 0);
        send_point(-32'sd1000, 32'd0, 0);
        send_point(32'h80000000, 32'h80000000, 1);
        send_point(32'h7fffffff, 32'h80000000, 0);
        send_point(32'h80000000, 32'h7fffffff, 0);
        send_point(32'h40000000, 32'h40000000, 0);
        drain();

        set_config(1, -64'sd754974720, 48'hffffffffffff);
        send_point(32'd0, 32'd1000, 0);
        send_point(32'd0, -32'sd1000, 0);
        send_point(32'd25, 32'd5, 1);
        send_point(32'h7fffffff, 32'h7fffffff, 0);
        send_point(32'h80000000, 32'h80000000, 0);
        send_point(32'd1, -32'sd30, 1);
        drain();

        // input keeps offering while the output is held off
        set_config(0, 0, 48'd1 << 36);
        hold_req++;
        no_gaps = 1;
        repeat (300) random_point();
        no_gaps = 0;
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            r = {$urandom, $urandom};
            set_config($urandom_range(0, 1), longint'($urandom_range(0, 1509949440)) - 754974720,
                       r[47:0] >> $urandom_range(0, 40));
            repeat (120) random_point();
        end
        drain();

        $display("%0d points checked over %0d register writes, incl. pole, axis and stall cases",
                 sb.checked, cfg_writes);
        if (sb.errors == 0)
            $display("polar_stereo_xy_to_latlon_unit_tb: PASS");
        else
            $display("polar_stereo_xy_to_latlon_unit_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
